### hw/rtl/tfr_pkg.sv
package tfr_pkg;

    localparam logic [7:0] MAGIC_FIRST  = 8'h43;
    localparam logic [7:0] MAGIC_SECOND = 8'h42;

    localparam int unsigned HDR_LAST_IDX = 7;
    localparam int unsigned LEN_FIRST_IDX = 4;

    typedef enum logic [2:0] {
        KIND_HEADER        = 3'd0,
        KIND_PAYLOAD       = 3'd1,
        KIND_BAD_MAGIC     = 3'd2,
        KIND_BAD_LENGTH    = 3'd3,
        KIND_TYPE_MISMATCH = 3'd4,
        KIND_ACCEPTED      = 3'd5
    } t_kind;

    typedef enum logic {
        CFG_EXPECTED_TYPE = 1'b0,
        CFG_MAX_LENGTH    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         payload_byte;
        logic [7:0]         frame_type;
        logic signed [31:0] frame_length;
        logic               last;
    } t_result;

endpackage

### hw/rtl/typed_frame_receiver_core.sv
// Channel   Dir  Handshake                          Item
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  one received byte
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  kind, payload byte, type, length, last
// cfg       in   i_cfg_we (no wait)                 register index and value
//
// One item per cycle while the output is not stalled; each result appears in the cycle after its byte is taken,
// held in the single result register behind the header parser.
// Reset is synchronous on i_rst_n; all parser state and the result valid clear.
// A held result blocks the input only while i_m_axis_tready is low.
module typed_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                          // [47:16] frame_length
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_wdata
);
    import tfr_pkg::*;

    logic [7:0]  r_expected_type;
    logic [30:0] r_max_length;
    logic        r_out_valid;
    t_result     r_out;
    t_result     parse_result;
    logic        in_accept;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_type <= '0;
            r_max_length    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_EXPECTED_TYPE: r_expected_type <= i_cfg_wdata[7:0];
                CFG_MAX_LENGTH:    r_max_length    <= i_cfg_wdata;
                default:           r_max_length    <= r_max_length;
            endcase
        end
    end

    tfr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_rx_byte       (i_s_axis_tdata),
        .i_expected_type (r_expected_type),
        .i_max_length    (r_max_length),
        .o_result        (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= parse_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.frame_length, r_out.frame_type, r_out.payload_byte};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

    a_last_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == KIND_PAYLOAD))
        else $error("last set on a non-payload item");

    a_length_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.frame_length != 32'sd0))
        |-> ((r_out.kind == KIND_BAD_LENGTH) || (r_out.kind == KIND_ACCEPTED)))
        else $error("frame length reported outside a length check");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with an empty result register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("held result changed while stalled");

endmodule

### hw/rtl/tfr_parser.sv
module tfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_expected_type,
    input  logic [30:0]      i_max_length,
    output tfr_pkg::t_result o_result
);
    import tfr_pkg::*;

    logic [2:0]  r_header_count, n_header_count;
    logic        r_in_payload, n_in_payload;
    logic [1:0]  r_magic_ok, n_magic_ok;
    logic [7:0]  r_held_type, n_held_type;
    logic [23:0] r_length_accum, n_length_accum;
    logic [30:0] r_bytes_left, n_bytes_left;

    logic [31:0] full_len;
    logic        len_negative;
    logic [31:0] clamped_len;

    assign full_len     = {i_rx_byte, r_length_accum};
    assign len_negative = full_len[31];
    assign clamped_len  = (!len_negative && (full_len[30:0] > i_max_length))
                          ? {1'b0, i_max_length} : full_len;

    always_comb begin
        n_header_count = r_header_count;
        n_in_payload   = r_in_payload;
        n_magic_ok     = r_magic_ok;
        n_held_type    = r_held_type;
        n_length_accum = r_length_accum;
        n_bytes_left   = r_bytes_left;

        o_result.kind         = KIND_HEADER;
        o_result.payload_byte = '0;
        o_result.frame_type   = '0;
        o_result.frame_length = '0;
        o_result.last         = 1'b0;

        if (r_in_payload) begin
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_rx_byte;
            if (r_bytes_left <= 31'd1) begin
                o_result.last = 1'b1;
                n_bytes_left  = '0;
                n_in_payload  = 1'b0;
            end else begin
                n_bytes_left = r_bytes_left - 31'd1;
            end
        end else begin
            case (r_header_count)
                3'd0: begin
                    n_magic_ok = {1'b0, i_rx_byte == MAGIC_FIRST};
                end
                3'd1: begin
                    n_magic_ok = {i_rx_byte == MAGIC_SECOND, r_magic_ok[0]};
                end
                3'd2: begin
                    n_held_type = i_rx_byte;
                end
                default: begin
                    if (r_header_count >= 3'(LEN_FIRST_IDX)) begin
                        n_length_accum = {i_rx_byte, r_length_accum[23:8]};
                    end
                end
            endcase

            if (r_header_count != 3'(HDR_LAST_IDX)) begin
                n_header_count = r_header_count + 3'd1;
            end else begin
                n_header_count      = '0;
                o_result.frame_type = r_held_type;
                if (r_magic_ok != 2'b11) begin
                    o_result.kind = KIND_BAD_MAGIC;
                end else if (r_held_type != i_expected_type) begin
                    o_result.kind = KIND_TYPE_MISMATCH;
                end else begin
                    o_result.frame_length = clamped_len;
                    if (len_negative || (clamped_len == 32'd0)) begin
                        o_result.kind = KIND_BAD_LENGTH;
                    end else begin
                        o_result.kind = KIND_ACCEPTED;
                        n_bytes_left  = clamped_len[30:0];
                        n_in_payload  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count <= '0;
            r_in_payload   <= 1'b0;
            r_magic_ok     <= '0;
            r_held_type    <= '0;
            r_length_accum <= '0;
            r_bytes_left   <= '0;
        end else if (i_accept) begin
            r_header_count <= n_header_count;
            r_in_payload   <= n_in_payload;
            r_magic_ok     <= n_magic_ok;
            r_held_type    <= n_held_type;
            r_length_accum <= n_length_accum;
            r_bytes_left   <= n_bytes_left;
        end
    end

endmodule
